// File: hdl/decimal_line_command_parser_defines.svh
// ----------------------------------------------------------------------------
// Decimal line command parser assertion macros
// Shared concurrent assertion forms, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_LINE_COMMAND_PARSER_DEFINES_SVH
`define DECIMAL_LINE_COMMAND_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define DLCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same cycle implication");

`define DLCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle implication");

`else

`define DLCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define DLCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/dlcp_pkg.sv
// ----------------------------------------------------------------------------
// Decimal line command parser package
// Line capacity, character codes, parse phases and the parser state record.
// ----------------------------------------------------------------------------
package dlcp_pkg;

    localparam int unsigned LINE_CAP = 48;
    localparam int unsigned LEN_W    = $clog2(LINE_CAP);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic               neg;
        logic [31:0]        acc;
        logic [LEN_W-1:0]   len;
        logic signed [31:0] speed;
    } t_parse_state;

endpackage

// File: hdl/dlcp_if.sv
// ----------------------------------------------------------------------------
// Decimal line command parser channels
// Valid/ready channels for received bytes and for speed results.
// ----------------------------------------------------------------------------
interface dlcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface dlcp_speed_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] target_speed;
    logic               speed_updated;

    modport source (output valid, output target_speed, output speed_updated, input ready);
    modport sink (input valid, input target_speed, input speed_updated, output ready);
endinterface

// File: hdl/decimal_line_command_parser.sv
// ----------------------------------------------------------------------------
// Decimal line command parser
// Bytes from a serial receiver enter on i_rx, one byte per request. Each
// accepted byte produces exactly one result request on o_speed, carrying the
// currently held target speed and a flag that is set when that byte ended a
// non-empty line with CR or LF. A line is parsed with atoi rules as it
// arrives, and a byte that would overfill the line is dropped and restarts it.
// A byte is registered on acceptance, parsed from the input register and its
// result is registered, so it passes through the input and result registers.
// The block takes one byte per cycle while its results are taken; the state
// update is combinational from the input to the state and result registers.
// When the receiver stalls, the result register holds its request and the
// input register still takes one more byte before i_rx.ready falls.
// Synchronous reset clears both registers, the line and a target speed of 0.
// ----------------------------------------------------------------------------
`include "decimal_line_command_parser_defines.svh"

module decimal_line_command_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dlcp_byte_if.sink           i_rx,
    dlcp_speed_if.source        o_speed
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_out_valid;
    logic signed [31:0]     r_out_speed;
    logic                   r_out_updated;
    dlcp_pkg::t_parse_state r_state;
    dlcp_pkg::t_parse_state n_state;
    logic                   n_updated;
    logic                   out_free;
    logic                   advance;

    assign out_free   = !r_out_valid || o_speed.ready;
    assign advance    = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || advance;

    dlcp_step u_step (
        .i_state   (r_state),
        .i_byte    (r_in_byte),
        .o_state   (n_state),
        .o_updated (n_updated)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: dlcp_pkg::PH_SKIP, neg: 1'b0, acc: '0, len: '0,
                             speed: '0};
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_speed.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (advance) begin
            r_out_speed   <= n_state.speed;
            r_out_updated <= n_updated;
        end
    end

    assign o_speed.valid         = r_out_valid;
    assign o_speed.target_speed  = r_out_speed;
    assign o_speed.speed_updated = r_out_updated;

    `DLCP_ASSERT_IMP(a_len_in_range, i_clk, i_rst_n, 1'b1,
        {1'b0, r_state.len} < (dlcp_pkg::LEN_W + 1)'(dlcp_pkg::LINE_CAP))
    `DLCP_ASSERT_IMP(a_skip_is_clean, i_clk, i_rst_n, r_state.phase == dlcp_pkg::PH_SKIP,
        (r_state.acc == '0) && !r_state.neg)
    `DLCP_ASSERT_NEXT(a_update_restarts, i_clk, i_rst_n, advance && n_updated,
        (r_state.len == '0) && r_out_updated && (r_out_speed == r_state.speed))
    `DLCP_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, r_out_valid && !o_speed.ready,
        !advance)

endmodule

// File: hdl/dlcp_step.sv
// ----------------------------------------------------------------------------
// Decimal line command parser step
// Applies one received byte to the line and parse state.
// ----------------------------------------------------------------------------
module dlcp_step (
    input  dlcp_pkg::t_parse_state i_state,
    input  logic [7:0]             i_byte,
    output dlcp_pkg::t_parse_state o_state,
    output logic                   o_updated
);

    logic                     is_digit;
    logic                     is_space;
    logic                     is_sign;
    logic                     is_eol;
    logic                     has_room;
    logic [dlcp_pkg::LEN_W:0] len_inc;
    logic [31:0]              acc_times_ten;

    assign is_digit = (i_byte >= dlcp_pkg::CH_ZERO) && (i_byte <= dlcp_pkg::CH_NINE);
    assign is_space = (i_byte == dlcp_pkg::CH_SPACE) || (i_byte == dlcp_pkg::CH_TAB)
                   || (i_byte == dlcp_pkg::CH_VT) || (i_byte == dlcp_pkg::CH_FF);
    assign is_sign  = (i_byte == dlcp_pkg::CH_PLUS) || (i_byte == dlcp_pkg::CH_MINUS);
    assign is_eol   = (i_byte == dlcp_pkg::CH_CR) || (i_byte == dlcp_pkg::CH_LF);
    assign len_inc  = {1'b0, i_state.len} + {{dlcp_pkg::LEN_W{1'b0}}, 1'b1};
    assign has_room = len_inc < (dlcp_pkg::LEN_W + 1)'(dlcp_pkg::LINE_CAP);
    assign acc_times_ten = {i_state.acc[28:0], 3'b000} + {i_state.acc[30:0], 1'b0};

    always_comb begin
        o_state   = i_state;
        o_updated = 1'b0;
        if (is_eol) begin
            if (i_state.len != '0) begin
                o_state.speed = i_state.neg ? $signed((~i_state.acc) + 32'd1)
                                            : $signed(i_state.acc);
                o_updated     = 1'b1;
                o_state.phase = dlcp_pkg::PH_SKIP;
                o_state.neg   = 1'b0;
                o_state.acc   = '0;
                o_state.len   = '0;
            end
        end else if (has_room) begin
            o_state.len = len_inc[dlcp_pkg::LEN_W-1:0];
            if (i_state.phase != dlcp_pkg::PH_DONE) begin
                if (is_digit) begin
                    o_state.acc   = acc_times_ten + {28'd0, i_byte[3:0]};
                    o_state.phase = dlcp_pkg::PH_DIGITS;
                end else if ((i_state.phase == dlcp_pkg::PH_SKIP) && is_space) begin
                    o_state.phase = dlcp_pkg::PH_SKIP;
                end else if ((i_state.phase == dlcp_pkg::PH_SKIP) && is_sign) begin
                    o_state.neg   = (i_byte == dlcp_pkg::CH_MINUS);
                    o_state.phase = dlcp_pkg::PH_SIGN;
                end else begin
                    o_state.phase = dlcp_pkg::PH_DONE;
                end
            end
        end else begin
            o_state.phase = dlcp_pkg::PH_SKIP;
            o_state.neg   = 1'b0;
            o_state.acc   = '0;
            o_state.len   = '0;
        end
    end

endmodule

// File: bench/tb_decimal_line_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal line command parser testbench
// Sends received bytes as requests and keeps its own copy of the line parser
// state, so that it can work out the speed and update flag that each byte
// must return. Each result request is checked in order against those
// expectations. Directed lines cover signs, whitespace, stray bytes,
// magnitude wrap and a full line. A receiver hold-off, a mid-line drain and
// random lines follow, the latter mostly with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_decimal_line_command_parser;

    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned TOTAL_BYTES  = 1750;
    localparam int unsigned HOLD_CYCLES  = 250;

    typedef struct {
        logic signed [31:0] speed;
        logic               updated;
    } t_speed_rec;

    logic i_clk;
    logic i_rst_n;

    dlcp_byte_if  rx_ch ();
    dlcp_speed_if speed_ch ();

    decimal_line_command_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_speed (speed_ch)
    );

    t_speed_rec         speed_expected [$];
    dlcp_pkg::t_phase   line_phase;
    logic               line_neg;
    logic [31:0]        line_acc;
    int unsigned        line_len;
    logic signed [31:0] held_speed;

    int unsigned bytes_sent;
    int unsigned mismatches;
    int unsigned cycle_count;
    logic        sender_gaps_on;
    logic        receiver_gaps_on;
    logic        hold_request;
    logic        hold_taken;
    int unsigned hold_left;

    always #5 i_clk = ~i_clk;

    task clear_line();
        begin
            line_phase = dlcp_pkg::PH_SKIP;
            line_neg   = 1'b0;
            line_acc   = 32'd0;
            line_len   = 0;
        end
    endtask

    task track_byte(input logic [7:0] c);
        t_speed_rec rec;
        logic       is_digit;
        logic       is_space;
        begin
            is_digit = (c >= dlcp_pkg::CH_ZERO) && (c <= dlcp_pkg::CH_NINE);
            is_space = (c == dlcp_pkg::CH_SPACE) || (c == dlcp_pkg::CH_TAB)
                    || (c == dlcp_pkg::CH_VT) || (c == dlcp_pkg::CH_FF);
            rec.updated = 1'b0;
            if (c == dlcp_pkg::CH_CR || c == dlcp_pkg::CH_LF) begin
                if (line_len != 0) begin
                    held_speed = line_neg ? (32'd0 - line_acc) : line_acc;
                    rec.updated = 1'b1;
                    clear_line();
                end
            end else if (line_len + 1 < dlcp_pkg::LINE_CAP) begin
                line_len = line_len + 1;
                if (line_phase != dlcp_pkg::PH_DONE) begin
                    if (is_digit) begin
                        line_acc   = line_acc * 32'd10 + 32'(c - dlcp_pkg::CH_ZERO);
                        line_phase = dlcp_pkg::PH_DIGITS;
                    end else if (line_phase == dlcp_pkg::PH_SKIP && is_space) begin
                        line_phase = dlcp_pkg::PH_SKIP;
                    end else if (line_phase == dlcp_pkg::PH_SKIP
                            && (c == dlcp_pkg::CH_PLUS || c == dlcp_pkg::CH_MINUS)) begin
                        line_neg   = (c == dlcp_pkg::CH_MINUS);
                        line_phase = dlcp_pkg::PH_SIGN;
                    end else begin
                        line_phase = dlcp_pkg::PH_DONE;
                    end
                end
            end else begin
                clear_line();
            end
            rec.speed = held_speed;
            speed_expected.push_back(rec);
        end
    endtask

    task send_byte(input logic [7:0] c);
        begin
            if (sender_gaps_on && $urandom_range(0, 99) < 18) begin
                rx_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= c;
            @(posedge i_clk);
            while (!rx_ch.ready) @(posedge i_clk);
            track_byte(c);
            bytes_sent = bytes_sent + 1;
        end
    endtask

    task send_text(input string s);
        int i;
        begin
            for (i = 0; i < s.len(); i++) send_byte(s[i]);
        end
    endtask

    task wait_drained();
        begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
            while (speed_expected.size() != 0) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 3))
            0: pick_space = dlcp_pkg::CH_SPACE;
            1: pick_space = dlcp_pkg::CH_TAB;
            2: pick_space = dlcp_pkg::CH_VT;
            default: pick_space = dlcp_pkg::CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        pick_digit = dlcp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_end();
        pick_end = $urandom_range(0, 1) ? dlcp_pkg::CH_CR : dlcp_pkg::CH_LF;
    endfunction

    task send_random_line();
        int unsigned kind;
        int unsigned sign_kind;
        begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            end else if (kind < 14) begin
                repeat ($urandom_range(44, 52)) begin
                    send_byte($urandom_range(0, 4) == 0 ? pick_space() : pick_digit());
                end
                send_byte(pick_end());
            end else begin
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
                    send_byte(pick_space());
                end
                sign_kind = $urandom_range(0, 2);
                if (sign_kind == 1) send_byte(dlcp_pkg::CH_PLUS);
                if (sign_kind == 2) send_byte(dlcp_pkg::CH_MINUS);
                repeat ($urandom_range(0, 11)) send_byte(pick_digit());
                if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 6) == 0) begin
                    send_byte(dlcp_pkg::CH_CR);
                    send_byte(dlcp_pkg::CH_LF);
                end else begin
                    send_byte(pick_end());
                end
            end
        end
    endtask

    task test_directed_lines();
        begin
            send_byte(dlcp_pkg::CH_LF);
            send_text(" -12\r");
            send_text("+-3\n");
            send_text(" \t7x9\n");
        end
    endtask

    task test_magnitude_wrap();
        begin
            send_text("4294967301\n");
            send_text("-99999999999\r");
        end
    endtask

    task test_full_line();
        begin
            repeat (dlcp_pkg::LINE_CAP - 1) send_byte(pick_digit());
            send_byte(8'($urandom_range(0, 255)) | 8'h80);
            send_text("5\n");
        end
    endtask

    task test_receiver_hold_off();
        begin
            hold_request <= 1'b1;
            repeat (6) send_random_line();
        end
    endtask

    task test_sender_pause();
        begin
            send_text("-321");
            wait_drained();
            send_byte(dlcp_pkg::CH_CR);
        end
    endtask

    task test_random_lines(input int unsigned upto);
        begin
            while (bytes_sent < upto) send_random_line();
        end
    endtask

    always @(posedge i_clk) begin
        t_speed_rec rec;
        if (!i_rst_n) begin
            speed_ch.ready <= 1'b0;
        end else begin
            if (speed_ch.valid && speed_ch.ready) begin
                if (speed_expected.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("result with none expected: speed %0d updated %0b",
                                 speed_ch.target_speed, speed_ch.speed_updated);
                    end
                end else begin
                    rec = speed_expected.pop_front();
                    if (speed_ch.target_speed !== rec.speed
                            || speed_ch.speed_updated !== rec.updated) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected speed %0d updated %0b, got speed %0d updated %0b",
                                     rec.speed, rec.updated,
                                     speed_ch.target_speed, speed_ch.speed_updated);
                        end
                    end
                end
            end
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                speed_ch.ready <= 1'b0;
            end else begin
                speed_ch.ready <= receiver_gaps_on ? ($urandom_range(0, 99) >= 18) : 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        rx_ch.valid      = 1'b0;
        rx_ch.rx_byte    = 8'h00;
        speed_ch.ready   = 1'b0;
        bytes_sent       = 0;
        mismatches       = 0;
        cycle_count      = 0;
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
        hold_request     = 1'b0;
        hold_taken       = 1'b0;
        hold_left        = 0;
        held_speed       = 32'sd0;
        clear_line();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_lines();
        test_magnitude_wrap();
        test_full_line();
        test_receiver_hold_off();
        test_sender_pause();
        test_random_lines(900);
        sender_gaps_on   = 1'b0;
        receiver_gaps_on = 1'b0;
        test_random_lines(1200);
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
        test_random_lines(TOTAL_BYTES);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && speed_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/dlcp_pkg.sv
hdl/dlcp_if.sv
hdl/dlcp_step.sv
hdl/decimal_line_command_parser.sv
bench/tb_decimal_line_command_parser.sv
